// ===== rtl/read_alignment_seed_selector_macros.svh =====
// Assertion macros for the read alignment seed selector.
// Used by the top level; expects clk and rst to be in scope where expanded.
`ifndef READ_ALIGNMENT_SEED_SELECTOR_MACROS_SVH
`define READ_ALIGNMENT_SEED_SELECTOR_MACROS_SVH

// Same-cycle implication.
`define RASS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RASS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rass_pkg.sv =====
// Package for the read alignment seed selector: field widths, codes and the
// command/status structs between controller and datapath. No dependencies.
package rass_pkg;

  localparam int DEF_MAX_REPEATS = 16;

  localparam int COORD_W   = 31;
  localparam int LEN_W     = 16;
  localparam int OPT_W     = 3;
  localparam int IDXIN_W   = 4;
  localparam int RCNT_W    = 5;
  localparam int SEED_W    = 17;
  localparam int POS_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEN_W-1:0] MIN_SEED_RESET = 16'd5;

  typedef enum logic [1:0] {
    CMD_BEGIN = 2'd0,
    CMD_OP    = 2'd1,
    CMD_ENTRY = 2'd2
  } cmd_t;

  typedef enum logic [OPT_W-1:0] {
    OP_MATCH = 3'd0,
    OP_INS   = 3'd1,
    OP_MISM  = 3'd2,
    OP_DEL   = 3'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_NO_SEED    = 2'd1,
    ST_INVALID    = 2'd2,
    ST_UNKNOWN_OP = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLANK_START = 2'd0,
    REG_FLANK_LAST  = 2'd1,
    REG_REPEAT_CNT  = 2'd2,
    REG_MIN_SEED    = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic begin_read;
    logic write_entry;
    logic op_update;
    logic match_start;
    logic scan;
    logic final_gap;
    logic commit;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic region_ok;
    logic scan_stop;
    logic bad_op;
  } dp_sts_t;

endpackage

// ===== rtl/rass_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rass_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rass_ctrl.sv =====
// Controller for the read alignment seed selector: sequences word handling,
// the repeat table scan and the result hand-off. Depends on rass_pkg.
module rass_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        cmd,
  input  logic [2:0]        op_type,
  input  logic              last_op,
  input  logic              out_stall,
  input  rass_pkg::dp_sts_t sts,
  output logic              in_stall,
  output logic              out_valid,
  output rass_pkg::dp_cmd_t dp_cmd
);
  import rass_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SCAN   = 6'b000010,
    S_FINAL  = 6'b000100,
    S_EVAL   = 6'b001000,
    S_COMMIT = 6'b010000,
    S_REPORT = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   last_q;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_BEGIN: dp_cmd.begin_read = 1'b1;
            CMD_ENTRY: dp_cmd.write_entry = 1'b1;
            CMD_OP: begin
              if (!sts.bad_op && op_type == OP_MATCH) begin
                dp_cmd.match_start = 1'b1;
                state_next = sts.region_ok ? S_SCAN : S_COMMIT;
              end else begin
                dp_cmd.op_update = 1'b1;
                if (last_op) begin
                  state_next = S_REPORT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (sts.scan_stop) begin
          state_next = S_FINAL;
        end else begin
          dp_cmd.scan = 1'b1;
        end
      end
      S_FINAL: begin
        dp_cmd.final_gap = 1'b1;
        state_next = S_EVAL;
      end
      S_EVAL: state_next = S_COMMIT;
      S_COMMIT: begin
        dp_cmd.commit = 1'b1;
        state_next = last_q ? S_REPORT : S_IDLE;
      end
      S_REPORT: begin
        if (!out_valid || !out_stall) begin
          dp_cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (dp_cmd.match_start) begin
        last_q <= last_op;
      end
      if (dp_cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/rass_dp.sv =====
// Datapath for the read alignment seed selector: configuration, read state,
// repeat table, gap scan and result register. Depends on rass_pkg, rass_ram.
module rass_dp #(
  parameter int MAX_REPEATS = rass_pkg::DEF_MAX_REPEATS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rass_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rass_pkg::COORD_W-1:0]    cfg_data,
  input  logic [rass_pkg::COORD_W-1:0]    coordinate,
  input  logic [rass_pkg::COORD_W-1:0]    span_end,
  input  logic [rass_pkg::LEN_W-1:0]      read_length,
  input  logic [rass_pkg::OPT_W-1:0]      op_type,
  input  logic [rass_pkg::LEN_W-1:0]      op_count,
  input  logic [rass_pkg::IDXIN_W-1:0]    entry_index,
  input  rass_pkg::dp_cmd_t               dp_cmd,
  output rass_pkg::dp_sts_t               sts,
  output logic signed [rass_pkg::SEED_W-1:0] seed_index,
  output logic [rass_pkg::COORD_W-1:0]    seed_distance,
  output logic [1:0]                      status
);
  import rass_pkg::*;

  localparam int IDX_W = $clog2(MAX_REPEATS > 1 ? MAX_REPEATS : 2);
  localparam int CNT_W = $clog2(MAX_REPEATS + 1);

  // Configuration registers.
  logic [COORD_W-1:0] flank_start, flank_last;
  logic [RCNT_W-1:0]  repeat_count;
  logic [LEN_W-1:0]   min_seed;

  // Read state.
  logic [POS_W-1:0]   refpos, rbc, best_base;
  logic [COORD_W-1:0] top_gap;
  logic [LEN_W-1:0]   rlen;
  logic               bad_op;

  // Match run scan.
  logic [LEN_W-1:0]   cnt_q;
  logic [COORD_W-1:0] hi_q, p;
  logic [CNT_W-1:0]   idx_q, n_lim;
  logic [COORD_W-1:0] glo, ghi;
  logic               gvld;
  logic [COORD_W-1:0] sd, sp;
  logic               sfound;

  logic [2*COORD_W-1:0] rd_data;
  logic [COORD_W-1:0]   rs, re, rs_m1;
  logic                 entry_ok;

  logic signed [POS_W-1:0]   pos_s;
  logic [COORD_W-1:0]        lo_c;
  logic signed [POS_W+1:0]   hi_w, hi_c;

  logic [COORD_W-1:0] g_half, g_dist, g_base;
  logic [POS_W-1:0]   offset, new_base;

  logic signed [POS_W:0] bs_x, rlen_m1;
  status_t               st_c;

  assign entry_ok = 32'(entry_index) < 32'(MAX_REPEATS);

  rass_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_REPEATS)
  ) u_table (
    .clk   (clk),
    .we    (dp_cmd.write_entry && entry_ok),
    .waddr (IDX_W'(entry_index)),
    .wdata ({coordinate, span_end}),
    .raddr (dp_cmd.scan ? IDX_W'(idx_q + CNT_W'(1)) : '0),
    .rdata (rd_data)
  );

  assign rs    = rd_data[2*COORD_W-1:COORD_W];
  assign re    = rd_data[COORD_W-1:0];
  assign rs_m1 = rs - COORD_W'(1);

  assign n_lim = (32'(repeat_count) > 32'(MAX_REPEATS)) ? CNT_W'(MAX_REPEATS)
                                                          : CNT_W'(repeat_count);

  // Match run clipped to the flank window, worked out as the word is taken.
  assign pos_s = $signed(refpos);
  assign lo_c  = (pos_s < $signed({1'b0, flank_start})) ? flank_start
                                                          : refpos[COORD_W-1:0];
  assign hi_w  = $signed({{2{refpos[POS_W-1]}}, refpos}) + $signed({18'b0, op_count})
               - 34'sd1;
  assign hi_c  = (hi_w > $signed({3'b0, flank_last})) ? $signed({3'b0, flank_last})
                                                       : hi_w;

  assign sts.region_ok = hi_c >= $signed({3'b0, lo_c});
  assign sts.scan_stop = (idx_q == n_lim) || (p > hi_q);
  assign sts.bad_op    = bad_op;

  // The middle base of a gap; gaps are evaluated in the cycle after they are found.
  assign g_half = (ghi - glo) >> 1;
  assign g_dist = g_half + COORD_W'(1);
  assign g_base = glo + g_half;

  assign offset   = {1'b0, sp} - refpos;
  assign new_base = rbc + offset;

  assign bs_x    = $signed({best_base[POS_W-1], best_base});
  assign rlen_m1 = $signed({17'b0, rlen}) - 33'sd1;

  always_comb begin
    if (bad_op) begin
      st_c = ST_UNKNOWN_OP;
    end else if (bs_x < -33'sd1 || bs_x == 33'sd0 || bs_x >= rlen_m1) begin
      st_c = ST_INVALID;
    end else if (bs_x == -33'sd1) begin
      st_c = ST_NO_SEED;
    end else begin
      st_c = ST_VALID;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flank_start  <= '0;
      flank_last   <= '0;
      repeat_count <= '0;
      min_seed     <= MIN_SEED_RESET;
      refpos       <= '0;
      rbc          <= '0;
      best_base    <= '1;
      top_gap      <= COORD_W'(MIN_SEED_RESET);
      rlen         <= '0;
      bad_op       <= 1'b0;
      gvld         <= 1'b0;
      sfound       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FLANK_START: flank_start  <= cfg_data;
          REG_FLANK_LAST:  flank_last   <= cfg_data;
          REG_REPEAT_CNT:  repeat_count <= cfg_data[RCNT_W-1:0];
          REG_MIN_SEED:    min_seed     <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end

      if (dp_cmd.begin_read) begin
        refpos    <= {1'b0, coordinate};
        rbc       <= '0;
        best_base <= '1;
        top_gap   <= COORD_W'(min_seed);
        rlen      <= read_length;
        bad_op    <= 1'b0;
      end

      if (dp_cmd.op_update && !bad_op) begin
        case (op_type)
          OP_INS: rbc <= rbc + POS_W'(op_count);
          OP_MISM: begin
            refpos <= refpos + POS_W'(op_count);
            rbc    <= rbc + POS_W'(op_count);
          end
          OP_DEL: refpos <= refpos + POS_W'(op_count);
          OP_MATCH: ;
          default: bad_op <= 1'b1;
        endcase
      end

      if (dp_cmd.match_start) begin
        sfound <= 1'b0;
      end else if (gvld && (!sfound || g_dist >= sd)) begin
        sfound <= 1'b1;
      end
      gvld <= (dp_cmd.scan && p < rs) || (dp_cmd.final_gap && p <= hi_q);

      if (dp_cmd.commit) begin
        refpos <= refpos + POS_W'(cnt_q);
        rbc    <= rbc + POS_W'(cnt_q);
        if (sfound && sd >= top_gap) begin
          top_gap   <= sd;
          best_base <= new_base;
        end
      end
    end
  end

  // Scan payload registers.
  always_ff @(posedge clk) begin
    if (dp_cmd.match_start) begin
      cnt_q <= op_count;
      hi_q  <= hi_c[COORD_W-1:0];
      p     <= lo_c;
      idx_q <= '0;
    end
    if (dp_cmd.scan) begin
      idx_q <= idx_q + CNT_W'(1);
      if (p < rs) begin
        glo <= p;
        ghi <= (hi_q < rs_m1) ? hi_q : rs_m1;
        p   <= re;
      end else if (p < re) begin
        p <= re;
      end
    end
    if (dp_cmd.final_gap) begin
      glo <= p;
      ghi <= hi_q;
    end
    if (gvld && (!sfound || g_dist >= sd)) begin
      sd <= g_dist;
      sp <= g_base;
    end
    if (dp_cmd.out_load) begin
      status <= st_c;
      if (st_c == ST_VALID) begin
        seed_index    <= $signed(best_base[SEED_W-1:0]);
        seed_distance <= top_gap;
      end else begin
        seed_index    <= '1;
        seed_distance <= '0;
      end
    end
  end

endmodule

// ===== rtl/read_alignment_seed_selector.sv =====
// Top level of the read alignment seed selector: controller and datapath.
// Depends on rass_pkg, rass_ctrl, rass_dp, rass_ram and the macros header.
//
//   channel   direction  handshake            payload
//   in        in         in_valid / in_stall  cmd, coordinate, span_end, read_length,
//                                             op_type, op_count, entry_index, last_op
//   out       out        out_valid/out_stall  seed_index, seed_distance, status
//   cfg       in         cfg_we               cfg_index, cfg_data
//
// Begin read, table writes and non-match operations are handled as the word is taken.
// A match scans k repeat entries (at most min(repeat_count, MAX_REPEATS)), one entry
// a cycle from the table RAM, then passes through the final gap, eval and commit states.
// A match whose run misses the flank window goes straight to the commit state.
// The last operation then loads the result register in the report state, held while out_stall.
// Reset is synchronous; the repeat table is not cleared and holds nothing until written.
module read_alignment_seed_selector #(
  parameter int MAX_REPEATS = rass_pkg::DEF_MAX_REPEATS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rass_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rass_pkg::COORD_W-1:0]        cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          cmd,
  input  logic [rass_pkg::COORD_W-1:0]        coordinate,
  input  logic [rass_pkg::COORD_W-1:0]        span_end,
  input  logic [rass_pkg::LEN_W-1:0]          read_length,
  input  logic [rass_pkg::OPT_W-1:0]          op_type,
  input  logic [rass_pkg::LEN_W-1:0]          op_count,
  input  logic [rass_pkg::IDXIN_W-1:0]        entry_index,
  input  logic                                last_op,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [rass_pkg::SEED_W-1:0]  seed_index,
  output logic [rass_pkg::COORD_W-1:0]        seed_distance,
  output logic [1:0]                          status
);
  import rass_pkg::*;

`include "read_alignment_seed_selector_macros.svh"

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  rass_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .cmd       (cmd),
    .op_type   (op_type),
    .last_op   (last_op),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .dp_cmd    (dp_cmd)
  );

  rass_dp #(
    .MAX_REPEATS (MAX_REPEATS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .coordinate    (coordinate),
    .span_end      (span_end),
    .read_length   (read_length),
    .op_type       (op_type),
    .op_count      (op_count),
    .entry_index   (entry_index),
    .dp_cmd        (dp_cmd),
    .sts           (dp_sts),
    .seed_index    (seed_index),
    .seed_distance (seed_distance),
    .status        (status)
  );

  // The controller issues at most one datapath command per cycle.
  `RASS_ASSERT_IMPL(a_one_cmd, 1'b1, $onehot0(dp_cmd), "several datapath commands at once")
  // A result waiting to be taken is never overwritten.
  `RASS_ASSERT_IMPL(a_no_overwrite, dp_cmd.out_load, !out_valid || !out_stall, "result lost")
  // Beginning a read clears the sticky unknown-operation flag.
  `RASS_ASSERT_NEXT(a_begin_clears, dp_cmd.begin_read, !dp_sts.bad_op, "flag not cleared")
  // A match keeps the input side stalled while it is worked on.
  `RASS_ASSERT_NEXT(a_match_busy, dp_cmd.match_start, in_stall, "word taken during a match")

endmodule
